// ===== hdl/html_text_escape_encoder_defines.svh =====
// Assertion macros for the HTML text escape encoder.
// Depends on nothing; expects clk_i and rst_ni in the including scope.
`ifndef HTML_TEXT_ESCAPE_ENCODER_DEFINES_SVH
`define HTML_TEXT_ESCAPE_ENCODER_DEFINES_SVH

// Clocked check, disabled while reset is asserted
`define HTE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds through reset
`define HTE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hdl/hte_pkg.sv =====
// Shared types, character codes and entity tables for the text escape encoder.
// Depends on nothing.
package hte_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned ENT_MAX = 12;  // longest expansion in units
  localparam int unsigned IDX_W   = 4;   // holds 0 .. ENT_MAX

  // Configuration register indexes
  localparam logic REG_OUTPUT_MODE  = 1'b0;
  localparam logic REG_QUOTE_SPACES = 1'b1;

  // Source characters with special handling
  localparam logic [UNIT_W-1:0] CHR_TAB   = 16'h0009;
  localparam logic [UNIT_W-1:0] CHR_LF    = 16'h000A;
  localparam logic [UNIT_W-1:0] CHR_CR    = 16'h000D;
  localparam logic [UNIT_W-1:0] CHR_SPACE = 16'h0020;
  localparam logic [UNIT_W-1:0] CHR_QUOT  = 16'h0022;
  localparam logic [UNIT_W-1:0] CHR_AMP   = 16'h0026;
  localparam logic [UNIT_W-1:0] CHR_APOS  = 16'h0027;
  localparam logic [UNIT_W-1:0] CHR_LT    = 16'h003C;
  localparam logic [UNIT_W-1:0] CHR_GT    = 16'h003E;

  typedef enum logic [1:0] {
    MODE_HTML      = 2'd0,
    MODE_XML       = 2'd1,
    MODE_XML_ATTR  = 2'd2,
    MODE_PLAIN     = 2'd3
  } out_mode_e;

  // What one source unit expands into
  typedef enum logic [3:0] {
    KIND_PASS,
    KIND_AMP,
    KIND_LT,
    KIND_GT,
    KIND_QUOT,
    KIND_TAB,
    KIND_BR_HTML,
    KIND_BR_XML,
    KIND_APOS,
    KIND_NBSP
  } ent_kind_e;

  // Classifier result handed to the expander
  typedef struct packed {
    ent_kind_e kind;
    logic      drop;      // carriage return: no output, run kept
    logic      is_space;
  } class_t;

  // Number of output units for a kind
  function automatic logic [IDX_W-1:0] ent_len(input ent_kind_e kind);
    logic [IDX_W-1:0] len;
    case (kind)
      KIND_AMP:     len = 4'd5;
      KIND_LT:      len = 4'd4;
      KIND_GT:      len = 4'd4;
      KIND_QUOT:    len = 4'd6;
      KIND_TAB:     len = 4'd12;
      KIND_BR_HTML: len = 4'd5;
      KIND_BR_XML:  len = 4'd6;
      KIND_APOS:    len = 4'd6;
      KIND_NBSP:    len = 4'd6;
      default:      len = 4'd1;
    endcase
    return len;
  endfunction

  // Entity text, first character in the top byte, zero padded on the right
  function automatic logic [ENT_MAX*8-1:0] ent_text(input ent_kind_e kind);
    logic [ENT_MAX*8-1:0] txt;
    case (kind)
      KIND_AMP:     txt = {"&amp;", 56'h0};
      KIND_LT:      txt = {"&lt;", 64'h0};
      KIND_GT:      txt = {"&gt;", 64'h0};
      KIND_QUOT:    txt = {"&quot;", 48'h0};
      KIND_TAB:     txt = "&nbsp;&nbsp;";
      KIND_BR_HTML: txt = {"<br>", 8'h0A, 56'h0};
      KIND_BR_XML:  txt = {"<br/>", 8'h0A, 48'h0};
      KIND_APOS:    txt = {"&apos;", 48'h0};
      KIND_NBSP:    txt = {"&nbsp;", 48'h0};
      default:      txt = '0;
    endcase
    return txt;
  endfunction

  // Character at position idx of an entity
  function automatic logic [7:0] ent_char(input ent_kind_e kind,
                                          input logic [IDX_W-1:0] idx);
    logic [ENT_MAX*8-1:0] txt;
    txt = ent_text(kind);
    return txt[(ENT_MAX - 1 - int'(idx)) * 8 +: 8];
  endfunction

endpackage

// ===== hdl/hte_classify.sv =====
// Decides how one source code unit expands, given mode and space-run state.
// Depends on hte_pkg.
module hte_classify (
  input  logic [hte_pkg::UNIT_W-1:0] code_unit_i,
  input  hte_pkg::out_mode_e         mode_i,
  input  logic                       quote_spaces_i,
  input  logic                       prev_space_i,
  output hte_pkg::class_t            class_o
);
  import hte_pkg::*;

  // Kind selection per character
  always_comb begin
    class_o.drop     = (code_unit_i == CHR_CR);
    class_o.is_space = (code_unit_i == CHR_SPACE);
    case (code_unit_i)
      CHR_SPACE: class_o.kind = (quote_spaces_i && prev_space_i) ? KIND_NBSP : KIND_PASS;
      CHR_AMP:   class_o.kind = KIND_AMP;
      CHR_LT:    class_o.kind = KIND_LT;
      CHR_GT:    class_o.kind = KIND_GT;
      CHR_QUOT:  class_o.kind = KIND_QUOT;
      CHR_TAB:   class_o.kind = KIND_TAB;
      CHR_LF: begin
        case (mode_i)
          MODE_HTML: class_o.kind = KIND_BR_HTML;
          MODE_XML:  class_o.kind = KIND_BR_XML;
          default:   class_o.kind = KIND_PASS;
        endcase
      end
      CHR_APOS:  class_o.kind = (mode_i == MODE_XML_ATTR) ? KIND_APOS : KIND_PASS;
      default:   class_o.kind = KIND_PASS;
    endcase
  end

endmodule

// ===== hdl/html_text_escape_encoder.sv =====
// HTML text escape encoder top level: config registers, expander, output register.
// Depends on hte_pkg, hte_classify and html_text_escape_encoder_defines.svh.
//
// Takes one UTF-16 code unit per transaction and returns its escaped form as
// one or more output units, last_of_run_o marking the final unit of each input.
// The expansion register steps through an input's output units, so an input
// that expands to several units holds the input side until its last unit is
// loaded into the output register; plain units stream at one per cycle while
// the output is not stalled, via the expansion and output registers. A carriage
// return produces nothing. Config writes apply to inputs taken after the write.
`include "html_text_escape_encoder_defines.svh"

module html_text_escape_encoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration write port
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [1:0]                 cfg_data_i,
  // input channel
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [hte_pkg::UNIT_W-1:0] code_unit_i,
  input  logic                       first_of_text_i,
  // output channel
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [hte_pkg::UNIT_W-1:0] out_unit_o,
  output logic                       last_of_run_o
);
  import hte_pkg::*;

  out_mode_e           mode_q;
  logic                quote_q;
  logic                prev_space_q;
  logic                prev_eff;
  class_t              cls;

  logic                busy_q;
  ent_kind_e           kind_q;
  logic [UNIT_W-1:0]   unit_q;
  logic [IDX_W-1:0]    idx_q;

  logic                out_valid_q;
  logic [UNIT_W-1:0]   out_unit_q;
  logic                out_last_q;

  logic                load_out;
  logic                last_char;
  logic                in_acc;
  logic [UNIT_W-1:0]   char_d;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_HTML;
      quote_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_OUTPUT_MODE:  mode_q  <= out_mode_e'(cfg_data_i);
        REG_QUOTE_SPACES: quote_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Classify the incoming unit; a new text starts with no space run
  assign prev_eff = first_of_text_i ? 1'b0 : prev_space_q;

  hte_classify u_classify (
    .code_unit_i    (code_unit_i),
    .mode_i         (mode_q),
    .quote_spaces_i (quote_q),
    .prev_space_i   (prev_eff),
    .class_o        (cls)
  );

  // Handshake: expander steps when the output register can take a unit
  assign load_out   = busy_q && (!out_valid_q || out_ready_i);
  assign last_char  = (idx_q == ent_len(kind_q) - 4'd1);
  assign in_ready_o = !busy_q || (load_out && last_char);
  assign in_acc     = in_valid_i && in_ready_o;

  // Space-run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_space_q <= 1'b0;
    end else if (in_acc) begin
      prev_space_q <= cls.drop ? prev_eff : cls.is_space;
    end
  end

  // Expansion register: current kind and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else if (in_acc) begin
      busy_q <= !cls.drop;
      idx_q  <= '0;
    end else if (load_out) begin
      busy_q <= !last_char;
      idx_q  <= idx_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= cls.kind;
      unit_q <= code_unit_i;
    end
  end

  // Unit for the current position
  assign char_d = (kind_q == KIND_PASS) ? unit_q : {8'h00, ent_char(kind_q, idx_q)};

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_unit_q <= char_d;
      out_last_q <= last_char;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_unit_o    = out_unit_q;
  assign last_of_run_o = out_last_q;

  // Checks
  `HTE_ASSERT(a_idx_in_range, busy_q |-> (idx_q < ent_len(kind_q)), "expander index past entity end")
  `HTE_ASSERT(a_start_at_zero, (in_acc && !cls.drop) |=> (busy_q && idx_q == '0), "new item not started at first unit")
  `HTE_ASSERT(a_pass_single, (load_out && kind_q == KIND_PASS) |-> last_char, "pass-through unit not marked last")
  `HTE_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (!busy_q && !out_valid_q), "block not idle in reset")

endmodule
